// ===== rtl/cde_pkg.sv =====
package cde_pkg;

    // Width of the shared multiply and divide datapath (signed, two's complement).
    localparam int AW = 130;
    // Width of the serial multiplier's multiplier operand.
    localparam int BW = 64;
    localparam int MUL_CNT_W = 7;
    localparam int DIV_CNT_W = 6;
    localparam int QW = 64;

    localparam int DEPTH_DEFAULT = 64;
    localparam int MIN_FIT_PAIRS = 4;
    localparam int TOL_W = 17;

    localparam logic [63:0] PPM_ONE = 64'd1000000;
    localparam int PPM_BITS = 20;
    localparam logic [33:0] Q32_ONE = 34'h1_0000_0000;
    localparam logic signed [31:0] DELTA_LIMIT = 32'sh7FFF_FFFF;

    localparam int SLOPE_BITS = 34;
    localparam int OFFSET_QBITS = 48;

    localparam logic [TOL_W-1:0] JUMP_TOL_RESET = 17'd1000;
    localparam logic [TOL_W-1:0] SLOPE_TOL_RESET = 17'd10000;

    // Register indexes on the configuration port.
    localparam logic REG_JUMP_TOL = 1'b0;
    localparam logic REG_SLOPE_TOL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEC,
        ST_JUMP_L,
        ST_JUMP_R,
        ST_STORE,
        ST_ACC_RD,
        ST_ACC_CL,
        ST_ACC_XX,
        ST_ACC_XY,
        ST_ACC_END,
        ST_CXX_N,
        ST_CXX_S,
        ST_CXY_N,
        ST_CXY_S,
        ST_CHECK,
        ST_LHS,
        ST_LO,
        ST_HI,
        ST_DIV_S,
        ST_MUL_W,
        ST_MUL_SX,
        ST_DIV_O,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic mul_xx;
        logic mul_xy;
        logic acc_xy;
    } t_mac_ctl;

endpackage

// ===== rtl/cde_mul.sv =====
module cde_mul import cde_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [AW-1:0]    i_a,
    input  logic [BW-1:0]           i_b,
    input  logic [MUL_CNT_W-1:0]    i_nbits,
    output logic                    o_done,
    output logic signed [AW-1:0]    o_prod
);

    logic                   r_busy;
    logic                   r_done;
    logic [MUL_CNT_W-1:0]   r_cnt;
    logic signed [AW-1:0]   r_a;
    logic [BW-1:0]          r_b;
    logic signed [AW-1:0]   r_acc;

    // Shift-add: one multiplier bit per cycle, least significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a   <= r_a <<< 1;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt - MUL_CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/cde_div.sv =====
module cde_div import cde_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [AW-1:0]           i_num,
    input  logic [AW-1:0]           i_den_sh,
    input  logic [DIV_CNT_W-1:0]    i_nq,
    output logic                    o_done,
    output logic [QW-1:0]           o_quot,
    output logic                    o_rem_nz
);

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [AW-1:0]          r_rem;
    logic [AW-1:0]          r_d;
    logic [QW-1:0]          r_q;

    // Restoring division. The divisor arrives pre-shifted to the top quotient
    // bit and moves one place right per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nq;
                r_rem  <= i_num;
                r_d    <= i_den_sh;
                r_q    <= '0;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_rem >= r_d) begin
                        r_rem <= r_rem - r_d;
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_d   <= r_d >> 1;
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_q;
    assign o_rem_nz = (r_rem != '0);

endmodule

// ===== rtl/cde_mac.sv =====
module cde_mac import cde_pkg::*; #(
    parameter int CNT_W = 7
) (
    input  logic                        i_clk,
    input  t_mac_ctl                    i_ctl,
    input  logic [63:0]                 i_loc,
    input  logic [63:0]                 i_ref,
    input  logic [63:0]                 i_l0,
    input  logic [63:0]                 i_t0,
    output logic signed [32+CNT_W-1:0]  o_sx,
    output logic signed [32+CNT_W-1:0]  o_sy,
    output logic signed [64+CNT_W-1:0]  o_sxx,
    output logic signed [64+CNT_W-1:0]  o_sxy
);

    localparam int SW = 32 + CNT_W;
    localparam int XW = 64 + CNT_W;

    function automatic logic signed [31:0] clamp_delta(input logic [63:0] v,
                                                       input logic [63:0] origin);
        logic signed [64:0] d;
        d = $signed({1'b0, v}) - $signed({1'b0, origin});
        if (d > 65'(DELTA_LIMIT)) begin
            return DELTA_LIMIT;
        end else if (d < -65'(DELTA_LIMIT)) begin
            return -DELTA_LIMIT;
        end
        return d[31:0];
    endfunction

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [63:0] r_prod;
    logic signed [SW-1:0] r_sx;
    logic signed [SW-1:0] r_sy;
    logic signed [XW-1:0] r_sxx;
    logic signed [XW-1:0] r_sxy;

    logic signed [31:0] w_mb;
    logic signed [63:0] w_prod;

    // One 32x32 multiplier serves both x*x (under mul_xx) and x*y (under mul_xy).
    assign w_mb   = i_ctl.mul_xy ? r_y : r_x;
    assign w_prod = r_x * w_mb;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
        end
        if (i_ctl.load) begin
            r_x <= clamp_delta(i_loc, i_l0);
            r_y <= clamp_delta(i_ref, i_t0);
        end
        if (i_ctl.mul_xx) begin
            r_prod <= w_prod;
            r_sx   <= r_sx + SW'(r_x);
            r_sy   <= r_sy + SW'(r_y);
        end
        if (i_ctl.mul_xy) begin
            r_prod <= w_prod;
            r_sxx  <= r_sxx + XW'(r_prod);
        end
        if (i_ctl.acc_xy) begin
            r_sxy <= r_sxy + XW'(r_prod);
        end
    end

    assign o_sx  = r_sx;
    assign o_sy  = r_sy;
    assign o_sxx = r_sxx;
    assign o_sxy = r_sxy;

endmodule

// ===== rtl/clock_offset_drift_estimator.sv =====
// Channel   Direction  Handshake               Contents
// s_axis    in         tvalid/tready           calibration pair or clear request
// m_axis    out        tvalid/tready           current fit and pair count
// apb       in         psel/penable/pready     tolerance registers
//
// A clear or an ignored pair (reference zero) goes straight to the result; a stored pair with
// fewer than four pairs is stored and finishes, after the serial-multiply jump test where it
// applies. A full fit adds the per-entry accumulate pass over the window, then the bit-serial
// multiplier and divider.
// Reset is synchronous: count, position, fit and registers return to reset values; the
// window memory is not cleared. s_axis_tready is low while an item is in work; a result
// waits in the output register, and the next item may enter before it is taken.
module clock_offset_drift_estimator import cde_pkg::*; #(
    parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [127:0]        s_axis_tdata,   // local_time[63:0], ref_time[127:64]
    input  logic                s_axis_tuser,   // op
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // slope[33:0], offset[97:34], pair_count from bit 98, zero fill
    output logic [((98+$clog2(WINDOW_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    output logic                m_axis_tuser,   // fit_valid
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = 32 + CW;
    localparam int XW = 64 + CW;
    localparam int OW = ((98 + CW + 7) / 8) * 8;

    t_state r_state;
    t_state n_state;

    logic [63:0] r_mem_loc [WINDOW_DEPTH];
    logic [63:0] r_mem_ref [WINDOW_DEPTH];
    logic [63:0] r_rd_loc;
    logic [63:0] r_rd_ref;

    logic              r_op;
    logic [63:0]       r_loc;
    logic [63:0]       r_ref;
    logic [63:0]       r_last_loc;
    logic [63:0]       r_last_ref;
    logic [IW-1:0]     r_wp;
    logic [CW-1:0]     r_cnt;
    logic [IW-1:0]     r_idx;
    logic [33:0]       r_fit_slope;
    logic [63:0]       r_fit_off;
    logic              r_fit_ok;
    logic [TOL_W-1:0]  r_jt;
    logic [TOL_W-1:0]  r_st;
    logic              r_launch;
    logic signed [AW-1:0] r_tmp;
    logic signed [AW-1:0] r_cxx;
    logic signed [AW-1:0] r_cxy;
    logic signed [AW-1:0] r_v;
    logic [33:0]       r_s;
    logic [63:0]       r_term1;
    logic              r_out_valid;
    logic [33:0]       r_out_slope;
    logic [63:0]       r_out_off;
    logic              r_out_ok;
    logic [CW-1:0]     r_out_cnt;

    logic                   mul_start;
    logic signed [AW-1:0]   mul_a;
    logic [BW-1:0]          mul_b;
    logic [MUL_CNT_W-1:0]   mul_nb;
    logic                   mul_done;
    logic signed [AW-1:0]   mul_prod;
    logic                   div_start;
    logic [AW-1:0]          div_num;
    logic [AW-1:0]          div_den;
    logic [DIV_CNT_W-1:0]   div_nq;
    logic                   div_done;
    logic [QW-1:0]          div_quot;
    logic                   div_rem_nz;
    t_mac_ctl               mac_ctl;
    logic signed [SW-1:0]   sx;
    logic signed [SW-1:0]   sy;
    logic signed [XW-1:0]   sxx;
    logic signed [XW-1:0]   sxy;

    logic [64:0]    w_jump_a;
    logic [64:0]    w_jump_b;
    logic [64:0]    w_mag;
    logic [CW-1:0]  w_cnt_inc;
    logic [IW-1:0]  w_idx_last;
    logic [SW-1:0]  w_sx_abs;
    logic [AW-1:0]  w_v_abs;
    logic [63:0]    w_q_ceil;
    logic [63:0]    w_term2;
    logic           w_out_free;
    logic           w_cfg_wr;

    // |dr - dl| = |(ref + last_local) - (last_ref + local)|, all 65 bits wide.
    assign w_jump_a   = {1'b0, r_ref} + {1'b0, r_last_loc};
    assign w_jump_b   = {1'b0, r_last_ref} + {1'b0, r_loc};
    assign w_mag      = (w_jump_a >= w_jump_b) ? w_jump_a - w_jump_b : w_jump_b - w_jump_a;
    assign w_cnt_inc  = (r_cnt == CW'(WINDOW_DEPTH)) ? r_cnt : r_cnt + CW'(1);
    assign w_idx_last = IW'(r_cnt - CW'(1));
    assign w_sx_abs   = sx[SW-1] ? SW'(-sx) : SW'(sx);
    assign w_v_abs    = r_v[AW-1] ? AW'(-r_v) : AW'(r_v);
    // Floor division of a negative value: negate the rounded-up magnitude.
    assign w_q_ceil   = div_quot + 64'(div_rem_nz);
    assign w_term2    = r_v[AW-1] ? -w_q_ceil : div_quot;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    cde_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_nbits (mul_nb),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    cde_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den_sh (div_den),
        .i_nq     (div_nq),
        .o_done   (div_done),
        .o_quot   (div_quot),
        .o_rem_nz (div_rem_nz)
    );

    cde_mac #(
        .CNT_W (CW)
    ) u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_loc (r_rd_loc),
        .i_ref (r_rd_ref),
        .i_l0  (r_loc),
        .i_t0  (r_ref),
        .o_sx  (sx),
        .o_sy  (sy),
        .o_sxx (sxx),
        .o_sxy (sxy)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_DEC;
            end
            ST_DEC: begin
                if (r_op || r_ref == '0) begin
                    n_state = ST_FINISH;
                end else if (r_cnt != '0 && r_loc > r_last_loc) begin
                    n_state = ST_JUMP_L;
                end else begin
                    n_state = ST_STORE;
                end
            end
            ST_JUMP_L: if (mul_done) n_state = ST_JUMP_R;
            ST_JUMP_R: if (mul_done) n_state = ST_STORE;
            ST_STORE: begin
                if (w_cnt_inc < CW'(MIN_FIT_PAIRS)) n_state = ST_FINISH;
                else n_state = ST_ACC_RD;
            end
            ST_ACC_RD:  n_state = ST_ACC_CL;
            ST_ACC_CL:  n_state = ST_ACC_XX;
            ST_ACC_XX:  n_state = ST_ACC_XY;
            ST_ACC_XY:  n_state = ST_ACC_END;
            ST_ACC_END: begin
                if (r_idx == w_idx_last) n_state = ST_CXX_N;
                else n_state = ST_ACC_RD;
            end
            ST_CXX_N: if (mul_done) n_state = ST_CXX_S;
            ST_CXX_S: if (mul_done) n_state = ST_CXY_N;
            ST_CXY_N: if (mul_done) n_state = ST_CXY_S;
            ST_CXY_S: if (mul_done) n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_cxx[AW-1] || r_cxx == '0) n_state = ST_FINISH;
                else n_state = ST_LHS;
            end
            ST_LHS: if (mul_done) n_state = ST_LO;
            ST_LO: begin
                if (mul_done) n_state = (r_tmp < mul_prod) ? ST_FINISH : ST_HI;
            end
            ST_HI: begin
                if (mul_done) n_state = (r_tmp > mul_prod) ? ST_FINISH : ST_DIV_S;
            end
            ST_DIV_S:  if (div_done) n_state = ST_MUL_W;
            ST_MUL_W:  if (mul_done) n_state = ST_MUL_SX;
            ST_MUL_SX: if (mul_done) n_state = ST_DIV_O;
            ST_DIV_O:  if (div_done) n_state = ST_FINISH;
            ST_FINISH: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: unit operands, starts and accumulate controls.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        mul_a     = '0;
        mul_b     = '0;
        mul_nb    = '0;
        div_num   = '0;
        div_den   = '0;
        div_nq    = '0;
        mac_ctl   = '0;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (r_state)
            ST_JUMP_L: begin
                mul_a  = AW'(w_mag);
                mul_b  = PPM_ONE;
                mul_nb = MUL_CNT_W'(PPM_BITS);
            end
            ST_JUMP_R: begin
                mul_a  = AW'(r_loc - r_last_loc);
                mul_b  = BW'(r_jt);
                mul_nb = MUL_CNT_W'(TOL_W);
            end
            ST_CXX_N: begin
                mul_a  = AW'(sxx);
                mul_b  = BW'(r_cnt);
                mul_nb = MUL_CNT_W'(CW);
            end
            ST_CXX_S: begin
                mul_a  = AW'(w_sx_abs);
                mul_b  = BW'(w_sx_abs);
                mul_nb = MUL_CNT_W'(SW);
            end
            ST_CXY_N: begin
                mul_a  = AW'(sxy);
                mul_b  = BW'(r_cnt);
                mul_nb = MUL_CNT_W'(CW);
            end
            ST_CXY_S: begin
                mul_a  = sx[SW-1] ? -AW'(sy) : AW'(sy);
                mul_b  = BW'(w_sx_abs);
                mul_nb = MUL_CNT_W'(SW);
            end
            ST_LHS: begin
                mul_a  = r_cxy;
                mul_b  = PPM_ONE;
                mul_nb = MUL_CNT_W'(PPM_BITS);
            end
            ST_LO: begin
                mul_a  = r_cxx;
                mul_b  = PPM_ONE - BW'(r_st);
                mul_nb = MUL_CNT_W'(PPM_BITS + 1);
            end
            ST_HI: begin
                mul_a  = r_cxx;
                mul_b  = PPM_ONE + BW'(r_st);
                mul_nb = MUL_CNT_W'(PPM_BITS + 1);
            end
            ST_MUL_W: begin
                mul_a  = AW'(r_s);
                mul_b  = r_loc;
                mul_nb = MUL_CNT_W'(64);
            end
            ST_MUL_SX: begin
                mul_a  = AW'(sx);
                mul_b  = BW'(r_s);
                mul_nb = MUL_CNT_W'(SLOPE_BITS);
            end
            ST_DIV_S: begin
                div_num = AW'(r_cxy) << 32;
                div_den = AW'(r_cxx) << (SLOPE_BITS - 1);
                div_nq  = DIV_CNT_W'(SLOPE_BITS);
            end
            ST_DIV_O: begin
                div_num = w_v_abs;
                div_den = AW'(r_cnt) << (OFFSET_QBITS - 1);
                div_nq  = DIV_CNT_W'(OFFSET_QBITS);
            end
            ST_STORE:   mac_ctl.clr    = 1'b1;
            ST_ACC_CL:  mac_ctl.load   = 1'b1;
            ST_ACC_XX:  mac_ctl.mul_xx = 1'b1;
            ST_ACC_XY:  mac_ctl.mul_xy = 1'b1;
            ST_ACC_END: mac_ctl.acc_xy = 1'b1;
            default: ;
        endcase
        if (r_state inside {ST_JUMP_L, ST_JUMP_R, ST_CXX_N, ST_CXX_S, ST_CXY_N,
                            ST_CXY_S, ST_LHS, ST_LO, ST_HI, ST_MUL_W, ST_MUL_SX}) begin
            mul_start = !r_launch;
        end
        if (r_state inside {ST_DIV_S, ST_DIV_O}) begin
            div_start = !r_launch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_STORE) begin
            r_mem_loc[r_wp] <= r_loc;
            r_mem_ref[r_wp] <= r_ref;
        end
        if (r_state == ST_ACC_RD) begin
            r_rd_loc <= r_mem_loc[r_idx];
            r_rd_ref <= r_mem_ref[r_idx];
        end
    end

    // Control state, fit and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_cnt       <= '0;
            r_fit_slope <= Q32_ONE;
            r_fit_off   <= '0;
            r_fit_ok    <= 1'b0;
            r_jt        <= JUMP_TOL_RESET;
            r_st        <= SLOPE_TOL_RESET;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mul_start || div_start) begin
                r_launch <= 1'b1;
            end else if (mul_done || div_done) begin
                r_launch <= 1'b0;
            end

            if (w_cfg_wr) begin
                case (paddr[2])
                    REG_JUMP_TOL:  r_jt <= pwdata[TOL_W-1:0];
                    REG_SLOPE_TOL: r_st <= pwdata[TOL_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_DEC: begin
                    if (r_op) begin
                        r_cnt       <= '0;
                        r_wp        <= '0;
                        r_fit_slope <= Q32_ONE;
                        r_fit_off   <= '0;
                        r_fit_ok    <= 1'b0;
                    end
                end
                ST_JUMP_R: begin
                    if (mul_done && r_tmp > mul_prod) begin
                        r_cnt <= '0;
                        r_wp  <= '0;
                    end
                end
                ST_STORE: begin
                    r_wp  <= (r_wp == IW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + IW'(1);
                    r_cnt <= w_cnt_inc;
                    if (w_cnt_inc < CW'(MIN_FIT_PAIRS)) begin
                        r_fit_slope <= Q32_ONE;
                        r_fit_off   <= r_ref - r_loc;
                        r_fit_ok    <= 1'b1;
                    end
                end
                ST_DIV_O: begin
                    if (div_done) begin
                        r_fit_slope <= r_s;
                        r_fit_off   <= r_term1 + w_term2;
                        r_fit_ok    <= 1'b1;
                    end
                end
                default: ;
            endcase

            if (r_state == ST_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= s_axis_tuser;
            r_loc <= s_axis_tdata[63:0];
            r_ref <= s_axis_tdata[127:64];
        end
        case (r_state)
            ST_JUMP_L: if (mul_done) r_tmp <= mul_prod;
            ST_STORE: begin
                r_last_loc <= r_loc;
                r_last_ref <= r_ref;
                r_idx      <= '0;
            end
            ST_ACC_END: begin
                if (r_idx != w_idx_last) r_idx <= r_idx + IW'(1);
            end
            ST_CXX_N: if (mul_done) r_cxx <= mul_prod;
            ST_CXX_S: if (mul_done) r_cxx <= r_cxx - mul_prod;
            ST_CXY_N: if (mul_done) r_cxy <= mul_prod;
            ST_CXY_S: if (mul_done) r_cxy <= r_cxy - mul_prod;
            ST_LHS:   if (mul_done) r_tmp <= mul_prod;
            ST_DIV_S: if (div_done) r_s <= div_quot[SLOPE_BITS-1:0];
            ST_MUL_W: if (mul_done) r_term1 <= r_ref - mul_prod[95:32];
            ST_MUL_SX: begin
                // floor((2^32*sum(y) - slope*sum(x)) / 2^32)
                if (mul_done) r_v <= ((AW'(sy) <<< 32) - mul_prod) >>> 32;
            end
            default: ;
        endcase
        if (r_state == ST_FINISH && w_out_free) begin
            r_out_slope <= r_fit_slope;
            r_out_off   <= r_fit_off;
            r_out_ok    <= r_fit_ok;
            r_out_cnt   <= r_cnt;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_JUMP_TOL:  prdata = 32'(r_jt);
            REG_SLOPE_TOL: prdata = 32'(r_st);
            default:       prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OW'({r_out_cnt, r_out_off, r_out_slope});
    assign m_axis_tuser  = r_out_ok;

endmodule

// ===== bench/testbench.sv =====
module testbench import cde_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int OUT_W = ((98 + $clog2(DEPTH + 1) + 7) / 8) * 8;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int ITEMS_PER_PHASE = 326;
    localparam logic [2:0] ADDR_JUMP_TOL = {REG_JUMP_TOL, 2'b00};
    localparam logic [2:0] ADDR_SLOPE_TOL = {REG_SLOPE_TOL, 2'b00};
    localparam logic OP_PAIR = 1'b0;
    localparam logic OP_CLEAR = 1'b1;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        logic [33:0] slope;
        logic [63:0] offset;
        logic        valid;
        logic [6:0]  count;
    } t_fit;

    typedef struct {
        logic        op;
        logic [63:0] loc;
        logic [63:0] rf;
        logic        typed;
        t_fit        fit;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [127:0]      s_axis_tdata = '0;   // local_time[63:0], ref_time[127:64]
    logic              s_axis_tuser = 1'b0; // op
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // slope[33:0], offset[97:34], pair_count[104:98]
    logic              m_axis_tuser;        // fit_valid
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    clock_offset_drift_estimator #(.WINDOW_DEPTH(DEPTH)) uut (.*);

    // Predictor state.
    logic [63:0]  win_loc [DEPTH];
    logic [63:0]  win_ref [DEPTH];
    int           wr_pos;
    int           n_pairs;
    logic [33:0]  cur_slope;
    logic [63:0]  cur_offset;
    logic         cur_ok;
    logic [16:0]  tol_jump;
    logic [16:0]  tol_slope;

    t_fit         pending_fits[$];
    t_stim_row    dir_rows[$];
    int           errors = 0;
    int           burst_left = 0;
    bit           gaps_on = 1'b1;
    bit           hold_off_req = 1'b0;
    int           hold_cnt = 0;
    int           ready_mode = 0;
    int           ready_cyc = 0;
    int           idle_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report(string what, logic [127:0] got, logic [127:0] want);
        $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    function automatic logic signed [63:0] clamp_delta(logic [63:0] v, logic [63:0] o);
        logic signed [65:0] d;
        d = $signed({2'b00, v}) - $signed({2'b00, o});
        if (d > 66'sd2147483647) return 64'sd2147483647;
        if (d < -66'sd2147483647) return -64'sd2147483647;
        return d[63:0];
    endfunction

    function automatic bit detects_jump(logic [63:0] loc, logic [63:0] rf);
        int last;
        logic [63:0] pl, pr, dl;
        logic signed [67:0] diff;
        logic [127:0] lhs, rhs;
        last = (wr_pos + DEPTH - 1) % DEPTH;
        pl = win_loc[last];
        pr = win_ref[last];
        if (loc <= pl) return 1'b0;
        dl = loc - pl;
        diff = $signed({4'b0, rf}) + $signed({4'b0, pl}) - $signed({4'b0, pr})
             - $signed({4'b0, loc});
        if (diff < 0) diff = -diff;
        lhs = 128'(diff) * 128'd1000000;
        rhs = 128'(tol_jump) * 128'(dl);
        return lhs > rhs;
    endfunction

    // Least-squares fit over the window, origin at the newest pair.
    function automatic void refit(logic [63:0] l0, logic [63:0] t0);
        logic signed [63:0]  x, y, sx, sy;
        logic signed [159:0] sxx, sxy, cxx, cxy, sxw, syw, nn, lhs, lo_b, hi_b;
        logic signed [159:0] num, den, q, r;
        logic [33:0] s;
        logic [97:0] prod;
        logic [63:0] term1;
        sx = 0; sy = 0; sxx = 0; sxy = 0;
        for (int i = 0; i < n_pairs; i++) begin
            x = clamp_delta(win_loc[i], l0);
            y = clamp_delta(win_ref[i], t0);
            sx += x;
            sy += y;
            sxw = x;
            syw = y;
            sxx += sxw * sxw;
            sxy += sxw * syw;
        end
        sxw = sx;
        syw = sy;
        nn = n_pairs;
        cxx = sxx * nn - sxw * sxw;
        cxy = sxy * nn - sxw * syw;
        if (cxx <= 0) return;
        lhs = cxy * 160'sd1000000;
        lo_b = cxx * (160'sd1000000 - $signed({143'b0, tol_slope}));
        hi_b = cxx * (160'sd1000000 + $signed({143'b0, tol_slope}));
        if (lhs < lo_b || lhs > hi_b) return;
        q = (cxy <<< 32) / cxx;
        s = q[33:0];
        prod = 98'(s) * 98'(l0);
        term1 = t0 - prod[95:32];
        num = (syw <<< 32) - $signed({126'b0, s}) * sxw;
        den = nn <<< 32;
        q = num / den;
        r = num % den;
        if (r != 0 && num < 0) q = q - 1;
        cur_slope = s;
        cur_offset = term1 + q[63:0];
        cur_ok = 1'b1;
    endfunction

    function automatic t_fit predict_fit(logic op, logic [63:0] loc, logic [63:0] rf);
        if (op == OP_CLEAR) begin
            n_pairs = 0;
            wr_pos = 0;
            cur_slope = Q32_ONE;
            cur_offset = '0;
            cur_ok = 1'b0;
        end else if (rf != 0) begin
            if (n_pairs > 0 && detects_jump(loc, rf)) begin
                n_pairs = 0;
                wr_pos = 0;
            end
            win_loc[wr_pos] = loc;
            win_ref[wr_pos] = rf;
            wr_pos = (wr_pos + 1) % DEPTH;
            if (n_pairs < DEPTH) n_pairs++;
            if (n_pairs < MIN_FIT_PAIRS) begin
                cur_slope = Q32_ONE;
                cur_offset = rf - loc;
                cur_ok = 1'b1;
            end else begin
                refit(loc, rf);
            end
        end
        return '{cur_slope, cur_offset, cur_ok, 7'(n_pairs)};
    endfunction

    task automatic send_item(logic op, logic [63:0] loc, logic [63:0] rf,
                             bit typed = 1'b0, t_fit want = '0);
        t_fit f;
        if (burst_left == 0) begin
            if (gaps_on) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {rf, loc};
        do @(posedge i_clk); while (!s_axis_tready);
        f = predict_fit(op, loc, rf);
        pending_fits.push_back(typed ? want : f);
        burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_fits.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_JUMP_TOL) tol_jump = value[16:0];
        else tol_slope = value[16:0];
        // Read back through the same port.
        @(negedge i_clk);
        psel <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[16:0] !== value[16:0]) report("register read", prdata, value[16:0]);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Well-formed drifting runs with noise: not-associated pairs, clears, wild pairs, jumps.
    task automatic random_phase(int items);
        logic [63:0] loc, rf, step, dr;
        int drift, run_left, k;
        run_left = 0;
        loc = 0;
        rf = 0;
        drift = 0;
        for (int sent = 0; sent < items; ) begin
            if (run_left == 0) begin
                run_left = $urandom_range(2, 90);
                loc = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom);
                rf = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                  : loc + 64'($urandom_range(0, 99999));
                drift = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 40000)) - 20000
                                                  : int'($urandom_range(0, 1600)) - 800;
            end
            k = $urandom_range(0, 99);
            if (k < 6) begin
                send_item(OP_PAIR, {$urandom, $urandom}, 64'd0);
            end else if (k < 8) begin
                send_item(OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
            end else if (k < 12) begin
                send_item(OP_PAIR, {$urandom, $urandom}, {$urandom, $urandom});
            end else begin
                step = ($urandom_range(0, 40) == 0) ? {31'b0, $urandom, 1'b1}
                                                    : 64'($urandom_range(50000, 150000));
                dr = step + 64'($signed(step) * drift / 1000000)
                   + 64'(int'($urandom_range(0, 6)) - 3);
                if (k < 15) dr = dr + 64'($urandom_range(100000, 2000000));
                loc = loc + step;
                rf = rf + dr;
                send_item(OP_PAIR, loc, rf);
            end
            run_left--;
            sent++;
        end
        drain();
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request.
    always @(negedge i_clk) begin
        ready_cyc++;
        if (ready_cyc % 64 == 0) ready_mode = $urandom_range(0, 2);
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            case (ready_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_axis_tready <= (ready_cyc % 5) > 1;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_fit want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_fits.size() == 0) begin
                report("unexpected result", m_axis_tdata, '0);
            end else begin
                want = pending_fits.pop_front();
                if (m_axis_tdata[33:0] !== want.slope)
                    report("slope", m_axis_tdata[33:0], want.slope);
                if (m_axis_tdata[97:34] !== want.offset)
                    report("offset", m_axis_tdata[97:34], want.offset);
                if (m_axis_tuser !== want.valid)
                    report("fit_valid", m_axis_tuser, want.valid);
                if (m_axis_tdata[104:98] !== want.count)
                    report("pair_count", m_axis_tdata[104:98], want.count);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("clock_offset_drift_estimator test failed");
            $finish;
        end
    end

    initial begin
        t_fit one_empty;
        wr_pos = 0;
        n_pairs = 0;
        cur_slope = Q32_ONE;
        cur_offset = '0;
        cur_ok = 1'b0;
        tol_jump = JUMP_TOL_RESET;
        tol_slope = SLOPE_TOL_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            win_loc[i] = '0;
            win_ref[i] = '0;
        end
        one_empty = '{Q32_ONE, 64'd0, 1'b0, 7'd0};

        // Directed rows; expectations typed where they are obvious.
        dir_rows.push_back('{OP_PAIR, 64'd500, 64'd0, 1'b1, one_empty});
        dir_rows.push_back('{OP_CLEAR, ALL_ONES, ALL_ONES, 1'b1, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd1000, 64'd5000, 1'b1,
                             '{Q32_ONE, 64'd4000, 1'b1, 7'd1}});
        dir_rows.push_back('{OP_PAIR, 64'd2000, 64'd6000, 1'b1,
                             '{Q32_ONE, 64'd4000, 1'b1, 7'd2}});
        dir_rows.push_back('{OP_PAIR, 64'd3000, 64'd7001, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd4000, 64'd8000, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd5000, 64'd9001, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd6000, 64'd20000, 1'b1,
                             '{Q32_ONE, 64'd14000, 1'b1, 7'd1}});
        dir_rows.push_back('{OP_PAIR, ALL_ONES, 64'd1, 1'b1,
                             '{Q32_ONE, 64'd2, 1'b1, 7'd1}});
        dir_rows.push_back('{OP_PAIR, 64'd0, ALL_ONES, 1'b1,
                             '{Q32_ONE, ALL_ONES, 1'b1, 7'd2}});
        dir_rows.push_back('{OP_PAIR, 64'd77, 64'd0, 1'b0, one_empty});
        dir_rows.push_back('{OP_CLEAR, 64'd0, 64'd0, 1'b1, one_empty});
        // Equal local values: zero variance keeps the few-pairs fit.
        dir_rows.push_back('{OP_PAIR, 64'd100, 64'd100, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd100, 64'd200, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd100, 64'd300, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd100, 64'd400, 1'b0, one_empty});
        dir_rows.push_back('{OP_CLEAR, 64'd0, 64'd0, 1'b1, one_empty});
        // Falling local values skip the jump test; the last pair fails it and restarts the window.
        dir_rows.push_back('{OP_PAIR, 64'd4000, 64'd4000, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd3000, 64'd3000, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd2000, 64'd2000, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd1000, 64'd1100, 1'b0, one_empty});
        dir_rows.push_back('{OP_PAIR, 64'd5000, 64'd5000, 1'b0, one_empty});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].loc, dir_rows[i].rf,
                      dir_rows[i].typed, dir_rows[i].fit);
        drain();

        random_phase(ITEMS_PER_PHASE);

        write_reg(ADDR_JUMP_TOL, 32'd0);
        write_reg(ADDR_SLOPE_TOL, 32'd0);
        hold_off_req = 1'b1;
        gaps_on = 1'b0;
        random_phase(ITEMS_PER_PHASE);
        gaps_on = 1'b1;

        write_reg(ADDR_JUMP_TOL, 32'd100000);
        write_reg(ADDR_SLOPE_TOL, 32'd100000);
        random_phase(ITEMS_PER_PHASE);

        write_reg(ADDR_JUMP_TOL, 32'd100000);
        write_reg(ADDR_SLOPE_TOL, 32'd0);
        random_phase(ITEMS_PER_PHASE);

        write_reg(ADDR_JUMP_TOL, 32'($urandom_range(0, 100000)));
        write_reg(ADDR_SLOPE_TOL, 32'($urandom_range(0, 100000)));
        random_phase(ITEMS_PER_PHASE);

        // Any further result after this point would be unexpected.
        repeat (1000) @(posedge i_clk);
        if (errors == 0) begin
            $display("clock_offset_drift_estimator test passed");
        end else begin
            $display("clock_offset_drift_estimator test failed");
        end
        $finish;
    end

endmodule

// ===== clock_offset_drift_estimator.f =====
rtl/cde_pkg.sv
rtl/cde_mul.sv
rtl/cde_div.sv
rtl/cde_mac.sv
rtl/clock_offset_drift_estimator.sv
bench/testbench.sv
